// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the Huffman bit decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CHD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define CHD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/chd_pkg.sv =====
// Shared constants, codes and types of the canonical Huffman bit decoder.
package chd_pkg;

  // Alphabet and code size
  localparam int unsigned NUM_SYMBOLS     = 288;
  localparam int unsigned MAX_CODE_LENGTH = 15;

  // Fixed field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SYM_W  = 9;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned STAT_W = 3;

  // Derived widths
  localparam int unsigned ADDR_W  = $clog2(NUM_SYMBOLS);
  localparam int unsigned SWEEP_W = $clog2(NUM_SYMBOLS + 1);
  localparam int unsigned CNT_W   = $clog2(NUM_SYMBOLS + 1);
  localparam int unsigned NUM_LEN = MAX_CODE_LENGTH + 1;
  localparam int unsigned CODE_W  = MAX_CODE_LENGTH;
  localparam int unsigned FIRST_W = MAX_CODE_LENGTH + 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_SET    = 2'd1,
    OP_BUILD  = 2'd2,
    OP_DECODE = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_SYMBOL    = 3'd1,
    ST_BUILT     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_OVERSUB   = 3'd4,
    ST_INVALID   = 3'd5,
    ST_NOT_READY = 3'd6
  } status_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [SYM_W-1:0]   symbol_index;
    logic [LEN_W-1:0]   code_length;
    logic               code_bit;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [SYM_W-1:0]   symbol;
    logic [LEN_W-1:0]   length;
  } result_t;

  // Length store port request
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [LEN_W-1:0]   wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } len_req_t;

  // Sorted symbol store port request
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [SYM_W-1:0]   wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } sym_req_t;

endpackage

// ===== hw/rtl/chd_in_if.sv =====
// Input channel of the Huffman bit decoder: command transactions.
interface chd_in_if;
  import chd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SYM_W-1:0]  symbol_index;
  logic [LEN_W-1:0]  code_length;
  logic              code_bit;

  modport source (
    output valid, opcode, symbol_index, code_length, code_bit,
    input  ready
  );

  modport sink (
    input  valid, opcode, symbol_index, code_length, code_bit,
    output ready
  );
endinterface

// ===== hw/rtl/chd_out_if.sv =====
// Output channel of the Huffman bit decoder: result transactions.
interface chd_out_if;
  import chd_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SYM_W-1:0]   decoded_symbol;
  logic [LEN_W-1:0]   decoded_length;

  modport source (
    output valid, status, decoded_symbol, decoded_length,
    input  ready
  );

  modport sink (
    input  valid, status, decoded_symbol, decoded_length,
    output ready
  );
endinterface

// ===== hw/rtl/chd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module chd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/chd_ctrl.sv =====
// Sequencer and shared datapath: length store sweeps, table build and bit decode.
module chd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  chd_pkg::item_t            item_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output chd_pkg::result_t          res_o,
  output chd_pkg::len_req_t         len_req_o,
  input  logic [chd_pkg::LEN_W-1:0] len_rdata_i,
  output chd_pkg::sym_req_t         sym_req_o,
  input  logic [chd_pkg::SYM_W-1:0] sym_rdata_i
);
  import chd_pkg::*;

  localparam int unsigned AVAIL_W = MAX_CODE_LENGTH + 3;
  localparam int unsigned ACC_W   = CODE_W + 3;
  localparam int unsigned NF_W    = FIRST_W + 2;
  localparam int unsigned NB_W    = SYM_W + 1;
  localparam int unsigned POS_W   = CODE_W + 2;

  // Sequencer states
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_COUNT = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_LOOP  = 4'd5;
  localparam logic [3:0] S_PLACE = 4'd6;
  localparam logic [3:0] S_DEC1  = 4'd7;
  localparam logic [3:0] S_DEC2  = 4'd8;
  localparam logic [3:0] S_DEC3  = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;

  function automatic result_t plain_res(input status_e st);
    plain_res = '{status: st, symbol: '0, length: '0};
  endfunction

  // Control state
  logic [3:0]          state_q, state_d;
  logic [SWEEP_W-1:0]  sweep_q, sweep_d;
  logic                pend_q, pend_d;
  logic [CNT_W-1:0]    counts_q [NUM_LEN];
  logic [CNT_W-1:0]    counts_d [NUM_LEN];
  logic                ready_q, ready_d;
  logic [CODE_W-1:0]   last_q, last_d;
  logic [LEN_W-1:0]    longest_q, longest_d;
  logic [CODE_W-1:0]   partial_q, partial_d;
  logic [LEN_W-1:0]    depth_q, depth_d;
  logic [FIRST_W-1:0]  first_q, first_d;
  logic [SYM_W-1:0]    base_q, base_d;
  logic [LEN_W-1:0]    dl_q, dl_d;

  // Working registers
  logic [ADDR_W-1:0]   pend_sym_q, pend_sym_d;
  logic [CNT_W-1:0]    offs_q [NUM_LEN];
  logic [CNT_W-1:0]    offs_d [NUM_LEN];
  logic [CNT_W-1:0]    total_q, total_d;
  logic [AVAIL_W-1:0]  avail_q, avail_d;
  logic [CNT_W-1:0]    offacc_q, offacc_d;
  logic [ACC_W-1:0]    codeacc_q, codeacc_d;
  logic [CNT_W-1:0]    prev_cnt_q, prev_cnt_d;
  logic                bit_q, bit_d;
  logic [LEN_W:0]      nd_q, nd_d;
  logic [NF_W-1:0]     nf_q, nf_d;
  logic [NB_W-1:0]     nb_q, nb_d;
  logic [CODE_W:0]     code_q, code_d;
  result_t             res_q, res_d;

  // Shared count table read port
  logic [LEN_W-1:0]    cnt_addr;
  logic [CNT_W-1:0]    cnt_rd;
  logic [CNT_W-1:0]    offs_rd;

  // Decode step one
  logic [LEN_W-1:0]    dsel;
  logic [LEN_W:0]      nd1;
  logic [NF_W-1:0]     sum1, nf1;
  logic [NB_W-1:0]     nb1;
  logic [CODE_W:0]     code1;
  logic [LEN_W-1:0]    shamt;
  logic [CODE_W-1:0]   lim;
  logic                bad1;

  // Decode step two
  logic                ge2, hit2, pos_ok;
  logic [CODE_W:0]     diff2;
  logic [POS_W-1:0]    pos2;

  // Build loop
  logic [AVAIL_W-1:0]  avail_n;
  logic [ACC_W-1:0]    code_n;

  logic                sweep_more, sweep_end, len_nz, place_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  assign sweep_more = (sweep_q < SWEEP_W'(NUM_SYMBOLS));
  assign sweep_end  = (sweep_q == SWEEP_W'(NUM_SYMBOLS));
  assign len_nz     = (len_rdata_i != '0);

  // Count table address follows the state
  always_comb begin
    case (state_q)
      S_LOOP:  cnt_addr = dl_q;
      S_DEC1:  cnt_addr = dsel;
      S_DEC2:  cnt_addr = nd_q[LEN_W-1:0];
      default: cnt_addr = len_rdata_i;
    endcase
  end
  assign cnt_rd   = counts_q[cnt_addr];
  assign offs_rd  = offs_q[len_rdata_i];
  assign place_ok = pend_q && len_nz && (offs_rd < CNT_W'(NUM_SYMBOLS));

  // Decode step one: next depth, first code, base and range check
  assign dsel  = (depth_q > LEN_W'(MAX_CODE_LENGTH)) ? LEN_W'(MAX_CODE_LENGTH) : depth_q;
  assign nd1   = (LEN_W+1)'(dsel) + (LEN_W+1)'(1);
  assign sum1  = NF_W'(first_q) + NF_W'(cnt_rd);
  assign nf1   = sum1 << 1;
  assign nb1   = NB_W'(base_q) + NB_W'(cnt_rd);
  assign code1 = {partial_q, bit_q};
  assign shamt = longest_q - nd1[LEN_W-1:0];
  assign lim   = last_q >> shamt;
  assign bad1  = (nd1 > (LEN_W+1)'(longest_q)) ||
                 (nd1 > (LEN_W+1)'(MAX_CODE_LENGTH)) ||
                 (code1 > (CODE_W+1)'(lim));

  // Decode step two: does the code land among this depth's leaves
  assign ge2    = (NF_W'(code_q) >= nf_q);
  assign diff2  = code_q - nf_q[CODE_W:0];
  assign hit2   = ge2 && (diff2 < (CODE_W+1)'(cnt_rd));
  assign pos2   = POS_W'(nb_q) + POS_W'(diff2);
  assign pos_ok = (pos2 < POS_W'(NUM_SYMBOLS));

  // Build loop arithmetic: Kraft budget and canonical code accumulator
  assign avail_n = avail_q + avail_q - AVAIL_W'(cnt_rd);
  assign code_n  = (codeacc_q + ACC_W'(prev_cnt_q)) << 1;

  // Memory requests
  always_comb begin
    len_req_o = '0;
    sym_req_o = '0;
    case (state_q)
      S_INIT, S_CLEAR: begin
        len_req_o.we    = 1'b1;
        len_req_o.waddr = sweep_q[ADDR_W-1:0];
      end
      S_IDLE: begin
        if (in_valid_i && (item_i.opcode == OP_SET) &&
            (item_i.symbol_index < SYM_W'(NUM_SYMBOLS))) begin
          len_req_o.we    = 1'b1;
          len_req_o.waddr = ADDR_W'(item_i.symbol_index);
          len_req_o.wdata = (item_i.code_length > LEN_W'(MAX_CODE_LENGTH)) ?
                            LEN_W'(MAX_CODE_LENGTH) : item_i.code_length;
        end
      end
      S_COUNT: begin
        len_req_o.re    = sweep_more;
        len_req_o.raddr = sweep_q[ADDR_W-1:0];
      end
      S_PLACE: begin
        len_req_o.re    = sweep_more;
        len_req_o.raddr = sweep_q[ADDR_W-1:0];
        sym_req_o.we    = place_ok;
        sym_req_o.waddr = offs_rd[ADDR_W-1:0];
        sym_req_o.wdata = SYM_W'(pend_sym_q);
      end
      S_DEC2: begin
        sym_req_o.re    = hit2 && pos_ok;
        sym_req_o.raddr = pos2[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    pend_d     = pend_q;
    counts_d   = counts_q;
    ready_d    = ready_q;
    last_d     = last_q;
    longest_d  = longest_q;
    partial_d  = partial_q;
    depth_d    = depth_q;
    first_d    = first_q;
    base_d     = base_q;
    dl_d       = dl_q;
    pend_sym_d = pend_sym_q;
    offs_d     = offs_q;
    total_d    = total_q;
    avail_d    = avail_q;
    offacc_d   = offacc_q;
    codeacc_d  = codeacc_q;
    prev_cnt_d = prev_cnt_q;
    bit_d      = bit_q;
    nd_d       = nd_q;
    nf_d       = nf_q;
    nb_d       = nb_q;
    code_d     = code_q;
    res_d      = res_q;

    case (state_q)
      // Clearing pass over the length store after reset
      S_INIT: begin
        sweep_d = sweep_q + SWEEP_W'(1);
        if (sweep_q == SWEEP_W'(NUM_SYMBOLS - 1)) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          case (item_i.opcode)
            OP_CLEAR: begin
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            OP_SET: begin
              res_d   = plain_res(ST_ACCEPTED);
              state_d = S_RESP;
            end
            OP_BUILD: begin
              for (int i = 0; i < NUM_LEN; i++) begin
                counts_d[i] = '0;
              end
              total_d   = '0;
              ready_d   = 1'b0;
              last_d    = '0;
              longest_d = '0;
              partial_d = '0;
              depth_d   = '0;
              first_d   = '0;
              base_d    = '0;
              sweep_d   = '0;
              pend_d    = 1'b0;
              state_d   = S_COUNT;
            end
            OP_DECODE: begin
              if (!ready_q) begin
                res_d   = plain_res(ST_NOT_READY);
                state_d = S_RESP;
              end else begin
                bit_d   = item_i.code_bit;
                state_d = S_DEC1;
              end
            end
            default: ;
          endcase
        end
      end

      S_CLEAR: begin
        sweep_d = sweep_q + SWEEP_W'(1);
        if (sweep_q == SWEEP_W'(NUM_SYMBOLS - 1)) begin
          sweep_d = '0;
          res_d   = plain_res(ST_ACCEPTED);
          state_d = S_RESP;
        end
      end

      // Histogram of code lengths, one symbol per cycle
      S_COUNT: begin
        if (sweep_more) begin
          sweep_d    = sweep_q + SWEEP_W'(1);
          pend_d     = 1'b1;
          pend_sym_d = sweep_q[ADDR_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && len_nz) begin
          counts_d[len_rdata_i] = cnt_rd + CNT_W'(1);
          total_d               = total_q + CNT_W'(1);
        end
        if (sweep_end) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (total_q == '0) begin
          res_d   = plain_res(ST_EMPTY);
          state_d = S_RESP;
        end else begin
          dl_d       = LEN_W'(1);
          avail_d    = AVAIL_W'(1);
          offacc_d   = '0;
          codeacc_d  = '0;
          prev_cnt_d = '0;
          state_d    = S_LOOP;
        end
      end

      // One code length per cycle: budget, slot offsets, last code
      S_LOOP: begin
        avail_d      = avail_n;
        offs_d[dl_q] = offacc_q;
        offacc_d     = offacc_q + cnt_rd;
        codeacc_d    = code_n;
        prev_cnt_d   = cnt_rd;
        dl_d         = dl_q + LEN_W'(1);
        if (cnt_rd != '0) begin
          last_d    = CODE_W'(code_n + ACC_W'(cnt_rd) - ACC_W'(1));
          longest_d = dl_q;
        end
        if (avail_n[AVAIL_W-1]) begin
          last_d    = '0;
          longest_d = '0;
          res_d     = plain_res(ST_OVERSUB);
          state_d   = S_RESP;
        end else if (dl_q == LEN_W'(MAX_CODE_LENGTH)) begin
          sweep_d = '0;
          pend_d  = 1'b0;
          state_d = S_PLACE;
        end
      end

      // Scatter symbols into their sorted slots
      S_PLACE: begin
        if (sweep_more) begin
          sweep_d    = sweep_q + SWEEP_W'(1);
          pend_d     = 1'b1;
          pend_sym_d = sweep_q[ADDR_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (place_ok) begin
          offs_d[len_rdata_i] = offs_rd + CNT_W'(1);
        end
        if (sweep_end) begin
          ready_d = 1'b1;
          res_d   = plain_res(ST_BUILT);
          state_d = S_RESP;
        end
      end

      S_DEC1: begin
        if (bad1) begin
          res_d   = plain_res(ST_INVALID);
          state_d = S_RESP;
        end else begin
          nd_d    = nd1;
          nf_d    = nf1;
          nb_d    = nb1;
          code_d  = code1;
          state_d = S_DEC2;
        end
      end

      S_DEC2: begin
        if (hit2 && pos_ok) begin
          state_d = S_DEC3;
        end else if (hit2 || !ge2) begin
          res_d   = plain_res(ST_INVALID);
          state_d = S_RESP;
        end else begin
          // Internal node: descend one level
          partial_d = code_q[CODE_W-1:0];
          depth_d   = nd_q[LEN_W-1:0];
          first_d   = nf_q[FIRST_W-1:0];
          base_d    = nb_q[SYM_W-1:0];
          res_d     = plain_res(ST_ACCEPTED);
          state_d   = S_RESP;
        end
      end

      // Leaf reached: emit symbol and return to the root
      S_DEC3: begin
        res_d     = '{status: ST_SYMBOL, symbol: sym_rdata_i, length: nd_q[LEN_W-1:0]};
        partial_d = '0;
        depth_d   = '0;
        first_d   = '0;
        base_d    = '0;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      sweep_q   <= '0;
      pend_q    <= 1'b0;
      for (int i = 0; i < NUM_LEN; i++) begin
        counts_q[i] <= '0;
      end
      ready_q   <= 1'b0;
      last_q    <= '0;
      longest_q <= '0;
      partial_q <= '0;
      depth_q   <= '0;
      first_q   <= '0;
      base_q    <= '0;
      dl_q      <= '0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      pend_q    <= pend_d;
      counts_q  <= counts_d;
      ready_q   <= ready_d;
      last_q    <= last_d;
      longest_q <= longest_d;
      partial_q <= partial_d;
      depth_q   <= depth_d;
      first_q   <= first_d;
      base_q    <= base_d;
      dl_q      <= dl_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    offs_q     <= offs_d;
    total_q    <= total_d;
    avail_q    <= avail_d;
    offacc_q   <= offacc_d;
    codeacc_q  <= codeacc_d;
    prev_cnt_q <= prev_cnt_d;
    bit_q      <= bit_d;
    nd_q       <= nd_d;
    nf_q       <= nf_d;
    nb_q       <= nb_d;
    code_q     <= code_d;
    res_q      <= res_d;
  end
endmodule

// ===== hw/rtl/canonical_huffman_bit_decoder.sv =====
// Canonical Huffman decoder top level: the command sequencer runs one transaction at a time.
// Set length and not-ready go from idle straight to the response; a decode bit passes step
// one, then step two unless step one finds it invalid, then a sorted symbol store read when
// a symbol completes; clear is one sweep of the length store; build is two sweeps of the
// length store (count and place) with a pass over every code length between them. After
// reset the length store is cleared in a pass over all NUM_SYMBOLS entries during which no
// command is taken. The result register lets the next command enter while a result still
// waits on the output.
`include "assert_macros.svh"

module canonical_huffman_bit_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  chd_in_if.sink    in_i,
  chd_out_if.source out_o
);
  import chd_pkg::*;

  item_t     item;
  result_t   res;
  logic      res_valid, res_ready, in_ready;
  len_req_t  len_req;
  sym_req_t  sym_req;
  logic [LEN_W-1:0] len_rdata;
  logic [SYM_W-1:0] sym_rdata;
  logic      out_vld_q;
  result_t   out_res_q;
  logic      out_sym, out_other, out_fields_nz;

  assign item.opcode       = opcode_e'(in_i.opcode);
  assign item.symbol_index = in_i.symbol_index;
  assign item.code_length  = in_i.code_length;
  assign item.code_bit     = in_i.code_bit;
  assign in_i.ready        = in_ready;

  chd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .len_req_o   (len_req),
    .len_rdata_i (len_rdata),
    .sym_req_o   (sym_req),
    .sym_rdata_i (sym_rdata)
  );

  // Per-symbol code lengths
  chd_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SYMBOLS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_req.we),
    .waddr_i (len_req.waddr),
    .wdata_i (len_req.wdata),
    .re_i    (len_req.re),
    .raddr_i (len_req.raddr),
    .rdata_o (len_rdata)
  );

  // Symbols sorted by code length, then value
  chd_ram #(.WIDTH(SYM_W), .DEPTH(NUM_SYMBOLS)) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_req.we),
    .waddr_i (sym_req.waddr),
    .wdata_i (sym_req.wdata),
    .re_i    (sym_req.re),
    .raddr_i (sym_req.raddr),
    .rdata_o (sym_rdata)
  );

  // Output register
  assign res_ready = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_res_q.status;
  assign out_o.decoded_symbol = out_res_q.symbol;
  assign out_o.decoded_length = out_res_q.length;

  // Output shortcuts for the checks
  assign out_sym       = out_o.valid && (out_o.status == ST_SYMBOL);
  assign out_other     = out_o.valid && (out_o.status != ST_SYMBOL);
  assign out_fields_nz = (out_o.decoded_symbol != '0) || (out_o.decoded_length != '0);

  // Checks
  `CHD_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready |=> !in_i.ready)
  `CHD_ASSERT(a_result_held, clk_i, rst_ni, res_valid && !res_ready |=> res_valid && $stable(res))
  `CHD_ASSERT(a_symbol_has_length, clk_i, rst_ni, out_sym |-> (out_o.decoded_length != '0))
  `CHD_NEVER(a_no_stray_symbol, clk_i, rst_ni, out_other && out_fields_nz)
endmodule

// ===== sim/chd_checker.sv =====
// Checker of the Huffman bit decoder: predicts every result and compares it field by field.
module chd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  chd_in_if    in_mon,
  chd_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   symbols_o,
  output int   invalid_o,
  output int   built_o,
  output int   rejected_o,
  output int   not_ready_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  // Predicted decoder state
  logic [LEN_W-1:0] len_mem   [NUM_SYMBOLS];
  int unsigned      len_cnt   [NUM_LEN];
  logic [SYM_W-1:0] sym_order [NUM_SYMBOLS];
  bit               tbl_ok;
  int unsigned      last_cw;
  int unsigned      max_len;
  int unsigned      walk_code;
  int unsigned      walk_depth;
  int unsigned      walk_first;
  int unsigned      walk_base;

  // Results predicted but not yet seen on the output
  result_t expected_results[$];

  int fails       = 0;
  int n_pending   = 0;
  int n_symbols   = 0;
  int n_invalid   = 0;
  int n_built     = 0;
  int n_rejected  = 0;
  int n_not_ready = 0;

  assign fail_count_o = fails;
  assign pending_o    = n_pending;
  assign symbols_o    = n_symbols;
  assign invalid_o    = n_invalid;
  assign built_o      = n_built;
  assign rejected_o   = n_rejected;
  assign not_ready_o  = n_not_ready;

  task automatic report(string what, int unsigned want, int unsigned got);
    $display("%0t ns chd_checker: %s: expected %0d, got %0d", $time, what, want, got);
    fails++;
  endtask

  function automatic void go_root();
    walk_code  = 0;
    walk_depth = 0;
    walk_first = 0;
    walk_base  = 0;
  endfunction

  // Count lengths, check the Kraft sum, sort symbols and find the last code
  function automatic status_e rebuild_table();
    int unsigned offs [NUM_LEN];
    int unsigned total;
    int unsigned cw;
    int unsigned l;
    longint      slots;
    total = 0;
    cw    = 0;
    slots = 1;
    foreach (len_cnt[d]) len_cnt[d] = 0;
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      l = len_mem[s];
      if (l != 0 && l <= MAX_CODE_LENGTH) begin
        len_cnt[l]++;
        total++;
      end
    end
    tbl_ok  = 1'b0;
    last_cw = 0;
    max_len = 0;
    go_root();
    if (total == 0) return ST_EMPTY;
    for (int d = 1; d <= MAX_CODE_LENGTH; d++) begin
      slots = slots * 2 - longint'(len_cnt[d]);
      if (slots < 0) return ST_OVERSUB;
    end
    offs[0] = 0;
    offs[1] = 0;
    for (int d = 2; d <= MAX_CODE_LENGTH; d++) offs[d] = offs[d-1] + len_cnt[d-1];
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      l = len_mem[s];
      if (l != 0 && l <= MAX_CODE_LENGTH && offs[l] < NUM_SYMBOLS) begin
        sym_order[offs[l]] = SYM_W'(s);
        offs[l]++;
      end
    end
    for (int d = 1; d <= MAX_CODE_LENGTH; d++) begin
      cw = (cw + len_cnt[d-1]) << 1;
      if (len_cnt[d] != 0) begin
        last_cw = cw + len_cnt[d] - 1;
        max_len = d;
      end
    end
    tbl_ok = 1'b1;
    return ST_BUILT;
  endfunction

  // One command in, one predicted result out
  function automatic result_t apply_command(item_t cmd);
    result_t     r;
    int unsigned d;
    int unsigned nd;
    int unsigned nf;
    int unsigned nb;
    int unsigned cw;
    int unsigned pos;
    r.status = ST_ACCEPTED;
    r.symbol = '0;
    r.length = '0;
    case (cmd.opcode)
      OP_CLEAR: begin
        foreach (len_mem[i]) len_mem[i] = '0;
      end
      OP_SET: begin
        if (cmd.symbol_index < NUM_SYMBOLS)
          len_mem[cmd.symbol_index] = (cmd.code_length > MAX_CODE_LENGTH) ?
                                      LEN_W'(MAX_CODE_LENGTH) : cmd.code_length;
      end
      OP_BUILD: begin
        r.status = rebuild_table();
      end
      default: begin
        if (!tbl_ok) begin
          r.status = ST_NOT_READY;
        end else begin
          d  = (walk_depth <= MAX_CODE_LENGTH) ? walk_depth : MAX_CODE_LENGTH;
          nd = d + 1;
          nf = (walk_first + len_cnt[d]) << 1;
          nb = walk_base + len_cnt[d];
          cw = (walk_code << 1) | cmd.code_bit;
          if (nd > max_len || nd > MAX_CODE_LENGTH || cw > (last_cw >> (max_len - nd))) begin
            r.status = ST_INVALID;
          end else if (cw >= nf && cw - nf < len_cnt[nd]) begin
            pos = nb + (cw - nf);
            if (pos < NUM_SYMBOLS) begin
              r.status = ST_SYMBOL;
              r.symbol = sym_order[pos];
              r.length = LEN_W'(nd);
              go_root();
            end else begin
              r.status = ST_INVALID;
            end
          end else if (cw < nf) begin
            r.status = ST_INVALID;
          end else begin
            // still inside the tree: descend
            walk_code  = cw;
            walk_depth = nd;
            walk_first = nf;
            walk_base  = nb;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Monitor both channels; results are checked before new commands are predicted
  always @(posedge clk_i or negedge rst_ni) begin
    item_t   cmd;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      foreach (len_mem[i]) len_mem[i] = '0;
      foreach (len_cnt[i]) len_cnt[i] = 0;
      foreach (sym_order[i]) sym_order[i] = '0;
      tbl_ok  = 1'b0;
      last_cw = 0;
      max_len = 0;
      go_root();
      expected_results.delete();
      n_pending = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status = status_e'(out_mon.status);
        got.symbol = out_mon.decoded_symbol;
        got.length = out_mon.decoded_length;
        if (expected_results.size() == 0) begin
          report("result with no command pending, status", 0, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report("status", want.status, got.status);
          if (got.symbol !== want.symbol) report("decoded_symbol", want.symbol, got.symbol);
          if (got.length !== want.length) report("decoded_length", want.length, got.length);
          case (want.status)
            ST_SYMBOL:    n_symbols++;
            ST_INVALID:   n_invalid++;
            ST_BUILT:     n_built++;
            ST_EMPTY,
            ST_OVERSUB:   n_rejected++;
            ST_NOT_READY: n_not_ready++;
            default: ;
          endcase
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd.opcode       = opcode_e'(in_mon.opcode);
        cmd.symbol_index = in_mon.symbol_index;
        cmd.code_length  = in_mon.code_length;
        cmd.code_bit     = in_mon.code_bit;
        expected_results.push_back(apply_command(cmd));
      end
      n_pending = expected_results.size();
    end
  end

endmodule

// ===== sim/tb_canonical_huffman_bit_decoder.sv =====
// Testbench top of the Huffman bit decoder: clock, reset, command stimulus and verdict.
module tb_canonical_huffman_bit_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  localparam int ITEM_TARGET  = 1150;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 150;
  localparam int DRAIN_CYCLES = 50;

  logic clk_i;
  logic rst_ni;

  chd_in_if  in_if ();
  chd_out_if out_if ();

  int fails;
  int pending;
  int n_symbols;
  int n_invalid;
  int n_built;
  int n_rejected;
  int n_not_ready;

  bit tx_burst;
  bit hold_active;
  int sent_cnt;
  int idle_cycles;

  // Code lengths of the table under construction and the symbols that carry them
  int unsigned code_lens[$];
  int unsigned live_syms[$];

  canonical_huffman_bit_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  chd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .symbols_o    (n_symbols),
    .invalid_o    (n_invalid),
    .built_o      (n_built),
    .rejected_o   (n_rejected),
    .not_ready_o  (n_not_ready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one command after a random gap (none during a burst or a hold) and wait until it is taken
  task automatic send_cmd(opcode_e op, int unsigned idx, int unsigned len, bit b);
    int gap;
    gap = (tx_burst || hold_active) ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.symbol_index <= idx[SYM_W-1:0];
    in_if.code_length  <= len[LEN_W-1:0];
    in_if.code_bit     <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
  endtask

  // Command whose unused fields carry noise
  task automatic send_op(opcode_e op);
    send_cmd(op, $urandom_range(0, 511), $urandom_range(0, 15), $urandom_range(0, 1));
  endtask

  // Complete prefix code: split random leaves until the wanted count is reached or the tries run out
  function automatic void grow_complete_code(int unsigned n_leaves);
    int unsigned i;
    int unsigned l;
    int          tries;
    code_lens = '{1, 1};
    tries = 0;
    while (code_lens.size() < n_leaves && tries < 1000) begin
      i = $urandom_range(0, code_lens.size() - 1);
      if (code_lens[i] < MAX_CODE_LENGTH) begin
        l = code_lens[i] + 1;
        code_lens[i] = l;
        code_lens.push_back(l);
      end
      tries++;
    end
  endfunction

  // Forget the old lengths, load a new code, build it and decode a random bit stream
  task automatic run_table_sequence();
    int unsigned shape;
    int unsigned s;
    int unsigned n_bits;
    bit          used [NUM_SYMBOLS];
    if (live_syms.size() > 0 && live_syms.size() <= 12 && $urandom_range(0, 1)) begin
      foreach (live_syms[i]) send_cmd(OP_SET, live_syms[i], 0, $urandom_range(0, 1));
    end else begin
      send_op(OP_CLEAR);
    end
    live_syms.delete();
    foreach (used[i]) used[i] = 1'b0;

    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      code_lens.delete();
    end else if (shape <= 3) begin
      // one code of every length, two at the deepest level
      code_lens.delete();
      for (int unsigned l = 1; l <= MAX_CODE_LENGTH; l++) code_lens.push_back(l);
      code_lens.push_back(MAX_CODE_LENGTH);
    end else begin
      grow_complete_code($urandom_range(2, 24));
    end
    // one extra code oversubscribes; a missing one leaves the code incomplete
    if (shape >= 4 && shape <= 6) begin
      code_lens.push_back($urandom_range(1, MAX_CODE_LENGTH));
    end else if ((shape == 7 || shape == 8 || shape == 2) && code_lens.size() > 1) begin
      code_lens.delete($urandom_range(0, code_lens.size() - 1));
    end

    foreach (code_lens[i]) begin
      do s = $urandom_range(0, NUM_SYMBOLS - 1); while (used[s]);
      used[s] = 1'b1;
      live_syms.push_back(s);
      send_cmd(OP_SET, s, code_lens[i], $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0)
        send_cmd(OP_SET, $urandom_range(NUM_SYMBOLS, 511), $urandom_range(0, 15),
                 $urandom_range(0, 1));
    end
    send_op(OP_BUILD);

    n_bits = $urandom_range(6, 40);
    repeat (n_bits) begin
      if ($urandom_range(0, 15) == 0) begin
        // length change after a build: the built table must keep decoding
        s = $urandom_range(0, NUM_SYMBOLS - 1);
        if (!used[s]) begin
          used[s] = 1'b1;
          live_syms.push_back(s);
        end
        send_cmd(OP_SET, s, $urandom_range(0, 15), $urandom_range(0, 1));
      end else begin
        send_cmd(OP_DECODE, $urandom_range(0, 511), $urandom_range(0, 15),
                 $urandom_range(0, 1));
      end
    end
  endtask

  // Main stimulus
  initial begin
    int unsigned fixed_len;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_CLEAR;
    in_if.symbol_index = '0;
    in_if.code_length  = '0;
    in_if.code_bit     = 1'b0;
    rst_ni             = 1'b0;
    tx_burst           = 1'b0;
    sent_cnt           = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: status codes, range limits and a table kept across later edits
    send_cmd(OP_DECODE, 0, 0, 0);                   // no table yet
    send_cmd(OP_BUILD, 511, 15, 1);                 // empty
    send_cmd(OP_SET, 511, 15, 1);                   // index out of range
    send_cmd(OP_SET, NUM_SYMBOLS, 9, 0);            // first index past the alphabet
    send_cmd(OP_BUILD, 0, 0, 0);                    // still empty
    send_cmd(OP_SET, 0, 1, 0);
    send_cmd(OP_SET, NUM_SYMBOLS - 1, 1, 1);
    send_cmd(OP_SET, 144, 1, 0);
    send_cmd(OP_BUILD, 0, 0, 0);                    // three codes of length one
    send_cmd(OP_DECODE, 0, 0, 1);                   // table rejected
    send_cmd(OP_SET, 144, 0, 1);
    send_cmd(OP_BUILD, 0, 0, 0);
    send_cmd(OP_DECODE, 0, 0, 0);
    send_cmd(OP_DECODE, 511, 15, 1);
    send_cmd(OP_SET, NUM_SYMBOLS - 1, MAX_CODE_LENGTH, 0);
    send_cmd(OP_DECODE, 0, 0, 1);                   // old table still in use
    send_cmd(OP_BUILD, 0, 0, 0);                    // incomplete code
    send_cmd(OP_DECODE, 0, 0, 1);
    send_cmd(OP_DECODE, 0, 0, 1);                   // leaves the tree
    send_cmd(OP_DECODE, 0, 0, 0);                   // resumes from the kept prefix
    send_cmd(OP_CLEAR, 0, 0, 0);
    send_cmd(OP_DECODE, 0, 0, 0);                   // cleared lengths, table kept
    send_cmd(OP_BUILD, 0, 0, 0);                    // empty now
    send_cmd(OP_DECODE, 0, 0, 0);

    // Fixed literal/length table of the deflate format over the whole alphabet
    send_op(OP_CLEAR);
    for (int unsigned s = 0; s < NUM_SYMBOLS; s++) begin
      if (s < 144)      fixed_len = 8;
      else if (s < 256) fixed_len = 9;
      else if (s < 280) fixed_len = 7;
      else              fixed_len = 8;
      send_cmd(OP_SET, s, fixed_len, $urandom_range(0, 1));
    end
    send_op(OP_BUILD);
    repeat (64) send_cmd(OP_DECODE, $urandom_range(0, 511), $urandom_range(0, 15),
                         $urandom_range(0, 1));
    live_syms.delete();

    // Random part: mostly well-formed tables, some loose commands
    while (sent_cnt < ITEM_TARGET) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 9))
            0:       send_op(OP_CLEAR);
            1:       send_op(OP_BUILD);
            2, 3, 4: send_op(OP_SET);
            default: send_op(OP_DECODE);
          endcase
        end
        // loose sets may leave lengths anywhere
        live_syms.delete();
      end else begin
        run_table_sequence();
      end
    end
    tx_burst = 1'b0;

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d commands, %0d tables built, %0d rejected, %0d decodes without a table",
             sent_cnt, n_built, n_rejected, n_not_ready);
    $display("run: %0d symbols decoded, %0d invalid code bits", n_symbols, n_invalid);
    if (fails == 0) begin
      $display("canonical_huffman_bit_decoder: match");
    end else begin
      $display("canonical_huffman_bit_decoder: mismatch");
    end
    $finish;
  end

  // Result receiver: random stall per transaction and one long hold-off
  initial begin
    int stall;
    int taken;
    bit rx_burst;
    bit held;
    out_if.ready = 1'b0;
    hold_active  = 1'b0;
    stall        = 0;
    taken        = 0;
    rx_burst     = 1'b0;
    held         = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && taken >= HOLD_AFTER) begin
        held        = 1'b1;
        hold_active = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_active = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        taken++;
        if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        stall = rx_burst ? 0 : $urandom_range(0, 12);
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               idle_cycles, pending);
      $display("canonical_huffman_bit_decoder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
